>>> hw/rtl/gps_pkg.sv
package gps_pkg;

   // fixed-point phase: 1 << PHASE_FRACTION_BITS is one full double step
   localparam int PHASE_FRACTION_BITS = 32;
   localparam int PHASE_W = PHASE_FRACTION_BITS + 1;

   localparam int DT_W   = 20;
   localparam int RATE_W = 20;
   localparam int DUR_W  = 32;
   localparam int PROD_W = DT_W + RATE_W;
   localparam int WIDE_W = (PROD_W > PHASE_W) ? PROD_W : PHASE_W;

   localparam logic [PHASE_W-1:0] PH_ONE = {1'b1, {PHASE_FRACTION_BITS{1'b0}}};
   localparam logic [PHASE_W-1:0] PH_HALF =
      {1'b0, 1'b1, {(PHASE_FRACTION_BITS - 1){1'b0}}};
   localparam logic [PHASE_W-1:0] PH_QUARTER =
      {2'b00, 1'b1, {(PHASE_FRACTION_BITS - 2){1'b0}}};

   localparam logic [DT_W-1:0]   DT_ZERO_US = DT_W'(100);
   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(8590);
   localparam logic [DUR_W-1:0]  DUR_RESET  = DUR_W'(500000);

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RATE      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_DURATION = 1'b1;

   // stream packing
   localparam int IN_BITS     = DT_W + 5;
   localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
   localparam int OUT_BITS    = PHASE_W + 9;
   localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

   typedef enum logic [2:0] {
      R_NONE       = 3'd0,
      R_START      = 3'd1,
      R_START_STEP = 3'd2,
      R_NORMAL     = 3'd3,
      R_KICK       = 3'd4,
      R_STOP_STEP  = 3'd5,
      R_STOP_MOVE  = 3'd6
   } rebuild_type;

   typedef struct packed {
      logic [DT_W-1:0] dt_us;
      logic            vel_cmd_zero;
      logic            walkable;
      logic            request_pause;
      logic            request_kick_left;
      logic            request_kick_right;
   } req_item_type;

   typedef struct packed {
      logic               active;
      logic [2:0]         walk_state;
      logic [PHASE_W-1:0] phase_out;
      logic               left_support_out;
      rebuild_type        rebuild_kind;
      logic               phase_fault;
   } rsp_item_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               half_done;
   } phase_adv_type;

endpackage

>>> hw/rtl/gps_phase_adv.sv
module gps_phase_adv import gps_pkg::*; (
   input  logic [DT_W-1:0]    dt_us,
   input  logic [RATE_W-1:0]  step_rate,
   input  logic [PHASE_W-1:0] phase,
   input  logic [PHASE_W-1:0] prev_phase,
   output phase_adv_type      adv
);

   logic [DT_W-1:0]    dt_eff;
   logic [PROD_W-1:0]  prod;
   logic [WIDE_W-1:0]  inc_wide;
   logic [PHASE_W-1:0] sum;
   logic [PHASE_W-1:0] next_phase;

   always_comb begin
      // a zero time step counts as the nominal tick
      dt_eff   = (dt_us == '0) ? DT_ZERO_US : dt_us;
      prod     = {{RATE_W{1'b0}}, dt_eff} * {{DT_W{1'b0}}, step_rate};
      inc_wide = WIDE_W'(prod);
      sum      = phase + PHASE_W'(inc_wide);
      if (inc_wide > WIDE_W'(PH_QUARTER)) begin
         next_phase = phase;
      end else if (sum > PH_ONE) begin
         next_phase = '0;
      end else begin
         next_phase = sum;
      end
      adv.phase     = next_phase;
      adv.half_done = (prev_phase < PH_HALF && next_phase >= PH_HALF) ||
                      (prev_phase > PH_HALF && next_phase < PH_HALF);
   end

endmodule

>>> hw/rtl/gps_sequencer.sv
module gps_sequencer import gps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  req_item_type       item,
   input  logic [RATE_W-1:0]  step_rate,
   input  logic [DUR_W-1:0]   pause_duration,
   output rsp_item_type       result
);

   typedef enum logic [2:0] {
      M_IDLE       = 3'd0,
      M_START_MOVE = 3'd1,
      M_START_STEP = 3'd2,
      M_WALK       = 3'd3,
      M_KICK       = 3'd4,
      M_STOP_STEP  = 3'd5,
      M_STOP_MOVE  = 3'd6,
      M_PAUSED     = 3'd7
   } mode_type;

   mode_type           mode_ff, mode_in, mode_eff;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PHASE_W-1:0] prev_ff, prev_in;
   logic [DUR_W-1:0]   paused_ff, paused_in;
   logic               left_ff, left_in;
   logic               pause_pend_ff, pause_pend_in;
   logic               kick_l_ff, kick_l_in;
   logic               kick_r_ff, kick_r_in;
   rsp_item_type       result_ff, result_in;

   phase_adv_type      adv;
   logic [DUR_W:0]     paused_sum;
   logic               pause_pend, kick_l, kick_r;
   logic               run, check, fault;

   gps_phase_adv u_phase_adv (
      .dt_us      (item.dt_us),
      .step_rate  (step_rate),
      .phase      (phase_ff),
      .prev_phase (prev_ff),
      .adv        (adv)
   );

   always_comb begin
      pause_pend = pause_pend_ff | item.request_pause;
      kick_l     = kick_l_ff | item.request_kick_left;
      kick_r     = kick_r_ff | item.request_kick_right;
      paused_sum = {1'b0, paused_ff} + (DUR_W + 1)'(item.dt_us);

      mode_in       = mode_ff;
      mode_eff      = mode_ff;
      phase_in      = phase_ff;
      prev_in       = prev_ff;
      paused_in     = paused_ff;
      left_in       = left_ff;
      pause_pend_in = pause_pend;
      kick_l_in     = kick_l;
      kick_r_in     = kick_r;
      result_in.rebuild_kind = R_NONE;
      result_in.active       = 1'b0;
      run   = 1'b0;
      check = 1'b0;
      fault = 1'b0;

      unique case (mode_ff)
         M_PAUSED: begin
            if (paused_ff > pause_duration) begin
               paused_in = '0;
               if (pause_pend) begin
                  pause_pend_in = 1'b0;
               end else begin
                  mode_eff = M_WALK;
                  run      = 1'b1;
               end
            end else begin
               paused_in = paused_sum[DUR_W] ? '1 : paused_sum[DUR_W-1:0];
            end
         end
         M_IDLE: run = !item.vel_cmd_zero && item.walkable;
         default: run = 1'b1;
      endcase

      if (run) begin
         phase_in = adv.phase;
         mode_in  = mode_eff;
         check    = 1'b1;
         unique case (mode_eff)
            M_IDLE: begin
               left_in = !left_ff;
               result_in.rebuild_kind = R_START;
               mode_in = M_START_MOVE;
            end
            M_START_MOVE: begin
               if (adv.half_done) begin
                  left_in = !left_ff;
                  if (item.vel_cmd_zero) begin
                     mode_in = M_STOP_MOVE;
                     result_in.rebuild_kind = R_STOP_MOVE;
                  end else begin
                     mode_in = M_START_STEP;
                     result_in.rebuild_kind = R_START_STEP;
                  end
               end
            end
            M_START_STEP: begin
               if (adv.half_done) begin
                  left_in = !left_ff;
                  if (item.vel_cmd_zero) begin
                     mode_in = M_STOP_STEP;
                     result_in.rebuild_kind = R_STOP_STEP;
                  end else begin
                     mode_in = M_WALK;
                     result_in.rebuild_kind = R_NORMAL;
                  end
               end
            end
            M_WALK: begin
               if (adv.half_done && pause_pend) begin
                  mode_in       = M_PAUSED;
                  pause_pend_in = 1'b0;
                  check         = 1'b0;
               end else if (adv.half_done &&
                            ((kick_l && !left_ff) || (kick_r && left_ff))) begin
                  left_in   = !left_ff;
                  mode_in   = M_KICK;
                  kick_l_in = 1'b0;
                  kick_r_in = 1'b0;
                  result_in.rebuild_kind = R_KICK;
               end else if (adv.half_done) begin
                  left_in = !left_ff;
                  if (item.vel_cmd_zero) begin
                     mode_in = M_STOP_STEP;
                     result_in.rebuild_kind = R_STOP_STEP;
                  end else begin
                     result_in.rebuild_kind = R_NORMAL;
                  end
               end
            end
            M_KICK: begin
               if (adv.half_done) begin
                  left_in = !left_ff;
                  mode_in = M_WALK;
                  result_in.rebuild_kind = R_NORMAL;
               end
            end
            M_STOP_STEP: begin
               if (adv.half_done) begin
                  left_in = !left_ff;
                  mode_in = M_STOP_MOVE;
                  result_in.rebuild_kind = R_STOP_MOVE;
               end
            end
            M_STOP_MOVE, M_PAUSED: begin
               if (adv.half_done) begin
                  mode_in = M_IDLE;
                  check   = 1'b0;
               end
            end
         endcase
         // support sanity check: phase half must match the support foot
         if (check) begin
            fault = (phase_in < PH_HALF && !left_in) ||
                    (phase_in >= PH_HALF && left_in);
            if (!fault) begin
               prev_in = phase_in;
               result_in.active = 1'b1;
            end
         end
      end

      result_in.walk_state       = mode_in;
      result_in.phase_out        = phase_in;
      result_in.left_support_out = left_in;
      result_in.phase_fault      = fault;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= M_IDLE;
         phase_ff      <= '0;
         prev_ff       <= '0;
         paused_ff     <= '0;
         left_ff       <= 1'b0;
         pause_pend_ff <= 1'b0;
         kick_l_ff     <= 1'b0;
         kick_r_ff     <= 1'b0;
      end else if (fire) begin
         mode_ff       <= mode_in;
         phase_ff      <= phase_in;
         prev_ff       <= prev_in;
         paused_ff     <= paused_in;
         left_ff       <= left_in;
         pause_pend_ff <= pause_pend_in;
         kick_l_ff     <= kick_l_in;
         kick_r_ff     <= kick_r_in;
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> hw/rtl/gait_phase_sequencer_unit.sv
// Gait phase sequencer: every req transfer is one control tick. The tick's
// requests are latched, the fixed-point step phase advances by dt_us times
// step_rate (a zero dt_us counts as 100 us, an increment above a quarter step
// is dropped, a phase above one wraps to zero), and the eight-state walk
// sequencer moves on; exactly one rsp transfer follows for each tick with the
// state, phase, support foot, sanity-check fault, active flag and the
// trajectory rebuild that software has to perform. Throughput is one tick per
// clock while rsp_tready stays high: a tick sits in the input register
// while the single 20x20 phase multiply, the phase compares and the
// sequencer update it into the state and result registers. req_tready
// follows rsp_tready combinationally, so a held result stalls at most the
// input register. csr_* writes take effect at once and are meant for
// an idle block only; after reset the block is ready at once.
module gait_phase_sequencer_unit import gps_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // dt_us[19:0], vel_cmd_zero, walkable, request_pause, request_kick_left,
   // request_kick_right, zero fill
   input  logic [IN_TDATA_W-1:0]  req_tdata,
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // active, walk_state[2:0], phase_out[32:0], left_support_out,
   // rebuild_kind[2:0], phase_fault, zero fill
   output logic [OUT_TDATA_W-1:0] rsp_tdata,
   // configuration writes
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DUR_W-1:0]       csr_wdata
);

   logic              in_valid_ff, in_valid_in;
   logic              out_valid_ff, out_valid_in;
   req_item_type      item_ff;
   logic [RATE_W-1:0] rate_ff;
   logic [DUR_W-1:0]  dur_ff;
   logic              req_xfer;
   logic              fire;
   rsp_item_type      result;

   // the tick in the input register moves on when the result slot frees up
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rate_ff      <= RATE_RESET;
         dur_ff       <= DUR_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wen) begin
            unique case (csr_index)
               CSR_STEP_RATE:      rate_ff <= csr_wdata[RATE_W-1:0];
               CSR_PAUSE_DURATION: dur_ff  <= csr_wdata;
            endcase
         end
      end
      // payload of the input register
      if (req_xfer) begin
         item_ff.dt_us              <= req_tdata[DT_W-1:0];
         item_ff.vel_cmd_zero       <= req_tdata[DT_W];
         item_ff.walkable           <= req_tdata[DT_W+1];
         item_ff.request_pause      <= req_tdata[DT_W+2];
         item_ff.request_kick_left  <= req_tdata[DT_W+3];
         item_ff.request_kick_right <= req_tdata[DT_W+4];
      end
   end

   // engine state, phase advance and result register
   gps_sequencer u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .item           (item_ff),
      .step_rate      (rate_ff),
      .pause_duration (dur_ff),
      .result         (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_TDATA_W'({result.phase_fault,
                                     result.rebuild_kind,
                                     result.left_support_out,
                                     result.phase_out,
                                     result.walk_state,
                                     result.active});

   // a processed tick always lands in the result slot
   a_fire_shows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("processed tick did not produce a result");

   // an active tick has passed the support sanity check
   a_active_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(result.active && result.phase_fault))
      else $error("active tick reports a support fault");

   // phase never exceeds one full double step
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (result.phase_out <= PH_ONE))
      else $error("phase out of range");

   // a waiting result holds still until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("waiting result changed before its transfer");

endmodule

>>> verif/gait_phase_sequencer_unit_checker.sv
`timescale 1ns / 100ps

module gait_phase_sequencer_unit_checker import gps_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // dt_us[19:0], vel_cmd_zero, walkable, request_pause, request_kick_left,
   // request_kick_right, zero fill
   input  logic [IN_TDATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // active, walk_state[2:0], phase_out[32:0], left_support_out,
   // rebuild_kind[2:0], phase_fault, zero fill
   input  logic [OUT_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DUR_W-1:0]       csr_wdata,
   output int                     mismatch_count,
   output int                     outstanding,
   output int                     responses_checked,
   output int                     rebuilds_seen,
   output int                     faults_seen,
   output int                     pauses_seen
);

   localparam logic [2:0] GAIT_IDLE       = 3'd0;
   localparam logic [2:0] GAIT_START_MOVE = 3'd1;
   localparam logic [2:0] GAIT_START_STEP = 3'd2;
   localparam logic [2:0] GAIT_WALK       = 3'd3;
   localparam logic [2:0] GAIT_KICK       = 3'd4;
   localparam logic [2:0] GAIT_STOP_STEP  = 3'd5;
   localparam logic [2:0] GAIT_STOP_MOVE  = 3'd6;
   localparam logic [2:0] GAIT_PAUSED     = 3'd7;

   logic [RATE_W-1:0]  rate_q;
   logic [DUR_W-1:0]   pause_len;
   logic [2:0]         gait_mode;
   logic [PHASE_W-1:0] phase_now;
   logic [PHASE_W-1:0] phase_last;
   logic [DUR_W-1:0]   paused_us;
   logic               support_left;
   logic               pause_req;
   logic               kick_l_req;
   logic               kick_r_req;

   rsp_item_type predicted_responses[$];

   function automatic rsp_item_type advance_gait(input req_item_type t);
      rsp_item_type r;
      logic [63:0]  step_us;
      logic [63:0]  incr;
      logic [63:0]  moved;
      logic [DUR_W:0] pause_sum;
      logic         stepping;
      logic         stopped;
      logic         crossed;
      logic         fault;
      logic         active;
      rebuild_type  kind;
      kind = R_NONE;
      fault = 1'b0;
      active = 1'b0;
      stepping = 1'b1;
      stopped = 1'b0;
      if (t.request_pause) pause_req = 1'b1;
      if (t.request_kick_left) kick_l_req = 1'b1;
      if (t.request_kick_right) kick_r_req = 1'b1;

      if (gait_mode == GAIT_PAUSED) begin
         if (paused_us > pause_len) begin
            paused_us = '0;
            if (pause_req) begin
               // pause restarts immediately
               pause_req = 1'b0;
               stepping = 1'b0;
            end else begin
               gait_mode = GAIT_WALK;
            end
         end else begin
            pause_sum = {1'b0, paused_us} + (DUR_W + 1)'(t.dt_us);
            paused_us = pause_sum[DUR_W] ? '1 : pause_sum[DUR_W-1:0];
            stepping = 1'b0;
         end
      end else if (gait_mode == GAIT_IDLE && (t.vel_cmd_zero || !t.walkable)) begin
         stepping = 1'b0;
      end

      if (stepping) begin
         step_us = (t.dt_us == '0) ? 64'(DT_ZERO_US) : 64'(t.dt_us);
         incr = step_us * 64'(rate_q);
         if (incr <= 64'(PH_QUARTER)) begin
            moved = 64'(phase_now) + incr;
            phase_now = (moved > 64'(PH_ONE)) ? '0 : moved[PHASE_W-1:0];
         end
         crossed = (phase_last < PH_HALF && phase_now >= PH_HALF) ||
                   (phase_last > PH_HALF && phase_now < PH_HALF);
         case (gait_mode)
            GAIT_IDLE: begin
               kind = R_START;
               gait_mode = GAIT_START_MOVE;
            end
            GAIT_START_MOVE: begin
               if (crossed && t.vel_cmd_zero) begin
                  gait_mode = GAIT_STOP_MOVE;
                  kind = R_STOP_MOVE;
               end else if (crossed) begin
                  gait_mode = GAIT_START_STEP;
                  kind = R_START_STEP;
               end
            end
            GAIT_START_STEP: begin
               if (crossed && t.vel_cmd_zero) begin
                  gait_mode = GAIT_STOP_STEP;
                  kind = R_STOP_STEP;
               end else if (crossed) begin
                  gait_mode = GAIT_WALK;
                  kind = R_NORMAL;
               end
            end
            GAIT_WALK: begin
               if (crossed && pause_req) begin
                  gait_mode = GAIT_PAUSED;
                  pause_req = 1'b0;
                  stopped = 1'b1;
                  pauses_seen++;
               end else if (crossed && ((kick_l_req && !support_left) ||
                                        (kick_r_req && support_left))) begin
                  gait_mode = GAIT_KICK;
                  kind = R_KICK;
                  kick_l_req = 1'b0;
                  kick_r_req = 1'b0;
               end else if (crossed && t.vel_cmd_zero) begin
                  gait_mode = GAIT_STOP_STEP;
                  kind = R_STOP_STEP;
               end else if (crossed) begin
                  kind = R_NORMAL;
               end
            end
            GAIT_KICK: begin
               if (crossed) begin
                  gait_mode = GAIT_WALK;
                  kind = R_NORMAL;
               end
            end
            GAIT_STOP_STEP: begin
               if (crossed) begin
                  gait_mode = GAIT_STOP_MOVE;
                  kind = R_STOP_MOVE;
               end
            end
            default: begin
               if (crossed) begin
                  gait_mode = GAIT_IDLE;
                  stopped = 1'b1;
               end
            end
         endcase
         // every rebuild swaps the support foot
         if (kind != R_NONE) begin
            support_left = !support_left;
            rebuilds_seen++;
         end
         if (!stopped) begin
            if ((phase_now < PH_HALF && !support_left) ||
                (phase_now >= PH_HALF && support_left)) begin
               fault = 1'b1;
               faults_seen++;
            end else begin
               phase_last = phase_now;
               active = 1'b1;
            end
         end
      end

      r.active = active;
      r.walk_state = gait_mode;
      r.phase_out = phase_now;
      r.left_support_out = support_left;
      r.rebuild_kind = kind;
      r.phase_fault = fault;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      req_item_type tick;
      if (reset) begin
         rate_q = RATE_RESET;
         pause_len = DUR_RESET;
         gait_mode = GAIT_IDLE;
         phase_now = '0;
         phase_last = '0;
         paused_us = '0;
         support_left = 1'b0;
         pause_req = 1'b0;
         kick_l_req = 1'b0;
         kick_r_req = 1'b0;
         predicted_responses.delete();
         mismatch_count = 0;
         responses_checked = 0;
         rebuilds_seen = 0;
         faults_seen = 0;
         pauses_seen = 0;
      end else begin
         if (csr_wen && csr_index == CSR_STEP_RATE) rate_q = csr_wdata[RATE_W-1:0];
         if (csr_wen && csr_index == CSR_PAUSE_DURATION) pause_len = csr_wdata;

         if (rsp_tvalid && rsp_tready) begin
            seen.active = rsp_tdata[0];
            seen.walk_state = rsp_tdata[3:1];
            seen.phase_out = rsp_tdata[4 +: PHASE_W];
            seen.left_support_out = rsp_tdata[4 + PHASE_W];
            seen.rebuild_kind = rebuild_type'(rsp_tdata[5 + PHASE_W +: 3]);
            seen.phase_fault = rsp_tdata[8 + PHASE_W];
            if (predicted_responses.size() == 0) begin
               $error("result transfer with no tick outstanding");
               mismatch_count++;
            end else begin
               want = predicted_responses.pop_front();
               responses_checked++;
               if (seen.active !== want.active) begin
                  $error("active: expected %0d, actual %0d", want.active, seen.active);
                  mismatch_count++;
               end
               if (seen.walk_state !== want.walk_state) begin
                  $error("walk_state: expected %0d, actual %0d",
                         want.walk_state, seen.walk_state);
                  mismatch_count++;
               end
               if (seen.phase_out !== want.phase_out) begin
                  $error("phase_out: expected %0h, actual %0h",
                         want.phase_out, seen.phase_out);
                  mismatch_count++;
               end
               if (seen.left_support_out !== want.left_support_out) begin
                  $error("left_support_out: expected %0d, actual %0d",
                         want.left_support_out, seen.left_support_out);
                  mismatch_count++;
               end
               if (seen.rebuild_kind !== want.rebuild_kind) begin
                  $error("rebuild_kind: expected %0d, actual %0d",
                         want.rebuild_kind, seen.rebuild_kind);
                  mismatch_count++;
               end
               if (seen.phase_fault !== want.phase_fault) begin
                  $error("phase_fault: expected %0d, actual %0d",
                         want.phase_fault, seen.phase_fault);
                  mismatch_count++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            tick.dt_us = req_tdata[DT_W-1:0];
            tick.vel_cmd_zero = req_tdata[DT_W];
            tick.walkable = req_tdata[DT_W + 1];
            tick.request_pause = req_tdata[DT_W + 2];
            tick.request_kick_left = req_tdata[DT_W + 3];
            tick.request_kick_right = req_tdata[DT_W + 4];
            predicted_responses.push_back(advance_gait(tick));
         end
      end
      outstanding = predicted_responses.size();
   end

endmodule

>>> verif/gait_phase_sequencer_unit_test.sv
`timescale 1ns / 100ps

module gait_phase_sequencer_unit_test;
   import gps_pkg::*;

   // quiet cycles tolerated: far more than the long receiver hold-off of
   // LONG_HOLD_CYCLES, and every other gap is far shorter
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTING_COUNT = 6;
   localparam int OPENING_COUNT = 22;
   localparam int DT_MAX = (1 << DT_W) - 1;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [IN_TDATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_STEP_RATE;
   logic [DUR_W-1:0]       csr_wdata = '0;

   int mismatch_count;
   int outstanding;
   int responses_checked;
   int rebuilds_seen;
   int faults_seen;
   int pauses_seen;

   // stimulus shaping and progress state for the sender, receiver and watchdog
   logic              idling_on = 1'b1;
   logic              long_hold_request = 1'b0;
   logic              long_hold_on = 1'b0;
   logic              halting = 1'b0;
   logic [RATE_W-1:0] rate_now = RATE_RESET;
   int                ticks_sent = 0;
   int                quiet_cycles = 0;

   gait_phase_sequencer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   gait_phase_sequencer_unit_checker gait_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding),
      .responses_checked (responses_checked),
      .rebuilds_seen     (rebuilds_seen),
      .faults_seen       (faults_seen),
      .pauses_seen       (pauses_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // time steps sized to the current step rate so the phase really moves,
   // plus zero steps, full-range noise and steps right at the quarter limit
   function automatic logic [DT_W-1:0] pick_dt();
      longint unsigned span;
      longint unsigned quarter_dt;
      int unsigned     roll;
      span = (rate_now == '0) ? DT_MAX : (64'd1 << 28) / rate_now;
      quarter_dt = (rate_now == '0) ? DT_MAX : (64'd1 << 30) / rate_now;
      if (span > DT_MAX) span = DT_MAX;
      if (span == 0) span = 1;
      if (quarter_dt >= DT_MAX) quarter_dt = DT_MAX - 1;
      roll = $urandom_range(0, 99);
      if (roll < 70) return DT_W'($urandom_range(1, int'(span)));
      if (roll < 78) return '0;
      if (roll < 88) return DT_W'($urandom_range(0, DT_MAX));
      return DT_W'(quarter_dt + $urandom_range(0, 1));
   endfunction

   // mostly walking orders with stretches of stopping; a slice of pure noise
   function automatic req_item_type random_tick();
      req_item_type t;
      if ($urandom_range(0, 39) == 0) halting = !halting;
      t.dt_us = pick_dt();
      if ($urandom_range(0, 9) == 0) begin
         t.vel_cmd_zero = 1'($urandom_range(0, 1));
         t.walkable = 1'($urandom_range(0, 1));
         t.request_pause = 1'($urandom_range(0, 1));
         t.request_kick_left = 1'($urandom_range(0, 1));
         t.request_kick_right = 1'($urandom_range(0, 1));
      end else begin
         t.vel_cmd_zero = halting ? ($urandom_range(0, 9) != 0)
                                  : ($urandom_range(0, 29) == 0);
         t.walkable = $urandom_range(0, 19) != 0;
         t.request_pause = $urandom_range(0, 39) == 0;
         t.request_kick_left = $urandom_range(0, 24) == 0;
         t.request_kick_right = $urandom_range(0, 24) == 0;
      end
      return t;
   endfunction

   // one tick on the input channel; entered and left at a falling edge
   task automatic send_tick(input req_item_type t);
      int gap;
      if (idling_on && !long_hold_on && $urandom_range(0, 15) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(IN_TDATA_W - IN_BITS){1'b0}}, t.request_kick_right,
                    t.request_kick_left, t.request_pause, t.walkable,
                    t.vel_cmd_zero, t.dt_us};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      ticks_sent++;
   endtask

   // drain every outstanding result before touching the registers
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_gait_regs(input logic [RATE_W-1:0] rate,
                                  input logic [DUR_W-1:0] dur);
      csr_wen <= 1'b1;
      csr_index <= CSR_STEP_RATE;
      csr_wdata <= DUR_W'(rate);
      @(negedge clock);
      csr_index <= CSR_PAUSE_DURATION;
      csr_wdata <= dur;
      @(negedge clock);
      csr_wen <= 1'b0;
      rate_now = rate;
   endtask

   // receiver: random back-pressure bursts plus one long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            long_hold_on = 1'b1;
            stall_left = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && idling_on && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            long_hold_on = 1'b0;
         end
      end
   end

   // any cycle with a transfer on either channel counts as progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, outstanding);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_item_type      opening_ticks[OPENING_COUNT];
      logic [RATE_W-1:0] setting_rate[SETTING_COUNT];
      logic [DUR_W-1:0]  setting_pause[SETTING_COUNT];
      int                setting_ticks[SETTING_COUNT];

      // flags after dt_us: vel_cmd_zero, walkable, request_pause,
      // request_kick_left, request_kick_right
      opening_ticks = '{
         {20'd1000,   5'b11000},   // idle with zero orders
         {20'd1000,   5'b00000},   // idle, not walkable
         {20'd0,      5'b01000},   // zero dt starts the walk
         {20'hFFFFF,  5'b01000},   // far too long a step
         {20'd125000, 5'b01000},   // just above a quarter step
         {20'd124999, 5'b01000},   // just below a quarter step
         {20'd124999, 5'b01000},   // crosses one half
         {20'd124999, 5'b01010},   // left kick request
         {20'd124999, 5'b01001},   // wraps past one, right kick request
         {20'd124999, 5'b01100},   // pause request
         {20'd124999, 5'b01000},
         {20'd124999, 5'b01000},
         {20'd124999, 5'b01000},
         {20'd124999, 5'b01000},
         {20'd124999, 5'b11000},   // stop orders
         {20'd124999, 5'b11000},
         {20'd124999, 5'b11000},
         {20'd124999, 5'b11000},
         {20'd124999, 5'b11000},
         {20'd1,      5'b11111},   // every flag at once
         {20'hFFFFF,  5'b10111},
         {20'd0,      5'b00000}
      };
      // register extremes: zero rate and zero pause, full rate and endless pause
      setting_rate  = '{20'd43000, 20'd0, 20'hFFFFF, 20'd1, 20'd8590, 20'd12000};
      setting_pause = '{32'd200000, 32'd0, 32'hFFFFFFFF, 32'd1, 32'd500000, 32'd60000};
      setting_ticks = '{300, 100, 150, 100, 300, 300};

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed ticks run on the reset register values
      foreach (opening_ticks[i]) send_tick(opening_ticks[i]);

      for (int s = 0; s < SETTING_COUNT; s++) begin
         wait_drained();
         write_gait_regs(setting_rate[s], setting_pause[s]);
         // last setting runs with both sides streaming flat out
         idling_on = (s != SETTING_COUNT - 1);
         if (s == 0) long_hold_request = 1'b1;
         for (int n = 0; n < setting_ticks[s]; n++) send_tick(random_tick());
      end

      wait_drained();
      repeat (8) @(negedge clock);

      $display("ran %0d ticks over %0d register settings, %0d results checked",
               ticks_sent, SETTING_COUNT + 1, responses_checked);
      $display("trajectory rebuilds %0d, support faults %0d, pauses entered %0d",
               rebuilds_seen, faults_seen, pauses_seen);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> gait_phase_sequencer_unit.f
hw/rtl/gps_pkg.sv
hw/rtl/gps_phase_adv.sv
hw/rtl/gps_sequencer.sv
hw/rtl/gait_phase_sequencer_unit.sv
verif/gait_phase_sequencer_unit_checker.sv
verif/gait_phase_sequencer_unit_test.sv
